FILE: rtl/core/cllm_pkg.sv
// shared field widths, operation codes and status codes of the linked list manager
package cllm_pkg;

  localparam int ModeBits   = 3;
  localparam int ListBits   = 4;
  localparam int FieldBits  = 16;
  localparam int StatusBits = 3;
  localparam int SlotBits   = 4;

  typedef enum logic [ModeBits-1:0] {
    MODE_CREATE = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_DELETE = 3'd4
  } mode_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_HEAD   = 3'd3,
    ST_BAD_LIST  = 3'd4
  } status_e;

endpackage

FILE: rtl/core/cursor_linked_list_manager.sv
// cursor array linked lists with a free list, walked one slot per cycle
// a rejected item goes from decode straight to done; other items walk their list slot by slot,
//   and create first scans list numbers upward for the lowest unused head
// one item at a time: a new item is accepted only in idle, after the last result has left done
// reset: free list holds all slots, no list in use, slot store links restored by valid bits
//   (no clearing pass); result register empty
module cursor_linked_list_manager #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cllm_pkg::ModeBits-1:0]    mode_i,
  input  logic [cllm_pkg::ListBits-1:0]    list_number_i,
  input  logic [cllm_pkg::FieldBits-1:0]   item_value_i,
  input  logic [cllm_pkg::FieldBits-1:0]   anchor_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cllm_pkg::StatusBits-1:0]  status_o,
  output logic [cllm_pkg::SlotBits-1:0]    slot_o,
  output logic [cllm_pkg::ListBits-1:0]    list_number_out_o
);

  localparam int HW = $clog2(SLOTS);
  localparam int LW = HW + 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_TAKE  = 4'd4;
  localparam logic [3:0] S_LINK2 = 4'd5;
  localparam logic [3:0] S_DEL1  = 4'd6;
  localparam logic [3:0] S_DEL2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [LW-1:0] rst_link(logic [HW-1:0] i);
    logic [LW-1:0] e;
    e = {1'b0, i};
    if (e == LW'(SLOTS - 1)) return '0;
    else if (e == LW'(SLOTS - 2)) return NIL;
    else return e + 1'b1;
  endfunction

  logic [3:0] state_q, state_d;
  logic [cllm_pkg::ModeBits-1:0] mode_q;
  logic [cllm_pkg::ListBits-1:0] lst_q;
  logic [VALUE_BITS-1:0] v_q, a_q;
  logic [LW-1:0] hd_q, hd_d;
  logic [HW-1:0] cur_q, cur_d, prev_q, prev_d, y_q, y_d, scan_q, scan_d;
  logic [LW-1:0] nxt_q, nxt_d, cnt_q, cnt_d;
  logic [LW-1:0] free_q, free_d;
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] link_wr_q;

  logic [cllm_pkg::StatusBits-1:0] res_st_q, res_st_d;
  logic [HW-1:0] res_slot_q, res_slot_d, res_lst_q, res_lst_d;
  logic out_valid_q;
  logic [cllm_pkg::StatusBits-1:0] status_q;
  logic [cllm_pkg::SlotBits-1:0] slot_q;
  logic [cllm_pkg::ListBits-1:0] lout_q;

  // slot store and head table
  logic [LW-1:0] link_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [HW-1:0] head_mem [SLOTS];
  logic [LW-1:0] lnk_raw_q, lnk_rd;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [HW-1:0] hd_rd_q;
  logic [HW-1:0] addr_q, rd_addr, hd_raddr;
  logic wr_hit_q;

  logic lw_en, vw_en, hw_en;
  logic [HW-1:0] lw_addr, hw_addr, hw_data;
  logic [LW-1:0] lw_data;

  logic [HW-1:0] lst_idx;
  logic lst_ok, accept, out_free;
  logic [VALUE_BITS-1:0] key;
  logic nx_nil, walk_last, special;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign lst_idx  = HW'(lst_q);
  assign lst_ok   = 32'(lst_q) < 32'(SLOTS);
  assign hd_raddr = (state_q == S_IDLE) ? HW'(list_number_i) : lst_idx;
  assign lnk_rd   = wr_hit_q ? lnk_raw_q : rst_link(addr_q);
  assign key      = (mode_q == cllm_pkg::MODE_INSERT) ? a_q : v_q;
  assign nx_nil   = lnk_rd >= NIL;
  assign walk_last = cnt_q == LW'(SLOTS - 1);
  assign special  = ({1'b0, cur_q} == hd_q) && (nxt_q >= NIL);

  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    if (vw_en) val_mem[y_d] <= v_q;
    if (hw_en) head_mem[hw_addr] <= hw_data;
    lnk_raw_q <= link_mem[rd_addr];
    val_rd_q  <= val_mem[rd_addr];
    hd_rd_q   <= head_mem[hd_raddr];
    addr_q    <= rd_addr;
  end

  always_comb begin
    state_d    = state_q;
    hd_d       = hd_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    y_d        = y_q;
    scan_d     = scan_q;
    nxt_d      = nxt_q;
    cnt_d      = cnt_q;
    free_d     = free_q;
    used_d     = used_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    res_lst_d  = res_lst_q;
    rd_addr    = free_q[HW-1:0];
    lw_en      = 1'b0;
    lw_addr    = cur_q;
    lw_data    = NIL;
    vw_en      = 1'b0;
    hw_en      = 1'b0;
    hw_addr    = lst_idx;
    hw_data    = y_q;

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISP;
      end
      S_DISP: begin
        res_slot_d = '0;
        res_lst_d  = '0;
        res_st_d   = cllm_pkg::ST_OK;
        if (lst_q == '0) hd_d = free_q;
        else if (used_q[lst_idx]) hd_d = {1'b0, hd_rd_q};
        else hd_d = NIL;
        cur_d  = hd_d[HW-1:0];
        prev_d = hd_d[HW-1:0];
        cnt_d  = '0;
        scan_d = HW'(1);
        rd_addr = hd_d[HW-1:0];
        if (mode_q == cllm_pkg::MODE_CREATE) begin
          if (free_q >= NIL) begin
            res_st_d = cllm_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end else if (mode_q > cllm_pkg::MODE_DELETE || !lst_ok) begin
          res_st_d = cllm_pkg::ST_BAD_LIST;
          state_d  = S_DONE;
        end else if (mode_q == cllm_pkg::MODE_SEARCH) begin
          if (hd_d >= NIL) begin
            res_st_d = cllm_pkg::ST_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end else if (lst_q == '0 || hd_d >= NIL) begin
          res_st_d = cllm_pkg::ST_BAD_LIST;
          state_d  = S_DONE;
        end else if (mode_q != cllm_pkg::MODE_DELETE && free_q >= NIL) begin
          res_st_d = cllm_pkg::ST_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_WALK;
        end
      end
      S_SCAN: begin
        // lowest head with no list; read port keeps fetching the free head
        if (!used_q[scan_q]) begin
          state_d = S_TAKE;
        end else if ({1'b0, scan_q} == LW'(SLOTS - 1)) begin
          res_st_d = cllm_pkg::ST_NO_HEAD;
          state_d  = S_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_WALK: begin
        if (mode_q == cllm_pkg::MODE_APPEND) begin
          if (nx_nil) begin
            state_d = S_TAKE;
          end else if (walk_last) begin
            cur_d   = lnk_rd[HW-1:0];
            state_d = S_TAKE;
          end else begin
            cur_d   = lnk_rd[HW-1:0];
            rd_addr = lnk_rd[HW-1:0];
            cnt_d   = cnt_q + 1'b1;
          end
        end else if (val_rd_q == key) begin
          nxt_d = lnk_rd;
          if (mode_q == cllm_pkg::MODE_SEARCH) begin
            res_slot_d = cur_q;
            state_d    = S_DONE;
          end else if (mode_q == cllm_pkg::MODE_INSERT) begin
            state_d = S_TAKE;
          end else begin
            state_d = S_DEL1;
          end
        end else if (nx_nil || walk_last) begin
          res_st_d = cllm_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          prev_d  = cur_q;
          cur_d   = lnk_rd[HW-1:0];
          rd_addr = lnk_rd[HW-1:0];
          cnt_d   = cnt_q + 1'b1;
        end
      end
      S_TAKE: begin
        // read data holds the link of the free head
        y_d        = free_q[HW-1:0];
        free_d     = lnk_rd;
        vw_en      = 1'b1;
        lw_en      = 1'b1;
        lw_addr    = y_d;
        res_slot_d = y_d;
        if (mode_q == cllm_pkg::MODE_CREATE) begin
          hw_en          = 1'b1;
          hw_addr        = scan_q;
          hw_data        = y_d;
          used_d[scan_q] = 1'b1;
          res_lst_d      = scan_q;
          state_d        = S_DONE;
        end else if (mode_q == cllm_pkg::MODE_INSERT && special) begin
          // lone anchor: new node goes in front of it
          lw_data = {1'b0, cur_q};
          hw_en   = 1'b1;
          hw_data = y_d;
          state_d = S_DONE;
        end else begin
          if (mode_q == cllm_pkg::MODE_INSERT) lw_data = nxt_q;
          state_d = S_LINK2;
        end
      end
      S_LINK2: begin
        lw_en   = 1'b1;
        lw_addr = cur_q;
        lw_data = {1'b0, y_q};
        state_d = S_DONE;
      end
      S_DEL1: begin
        if ({1'b0, cur_q} == hd_q) begin
          hw_en           = 1'b1;
          hw_data         = nxt_q[HW-1:0];
          used_d[lst_idx] = nxt_q < NIL;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_q;
          lw_data = nxt_q;
        end
        state_d = S_DEL2;
      end
      S_DEL2: begin
        lw_en      = 1'b1;
        lw_addr    = cur_q;
        lw_data    = free_q;
        free_d     = {1'b0, cur_q};
        res_slot_d = cur_q;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= LW'(SLOTS - 1);
      used_q      <= '0;
      link_wr_q   <= '0;
      wr_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      used_q   <= used_d;
      wr_hit_q <= link_wr_q[rd_addr];
      if (lw_en) link_wr_q[lw_addr] <= 1'b1;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      lst_q  <= list_number_i;
      v_q    <= VALUE_BITS'(item_value_i);
      a_q    <= VALUE_BITS'(anchor_value_i);
    end
    hd_q       <= hd_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    y_q        <= y_d;
    scan_q     <= scan_d;
    nxt_q      <= nxt_d;
    cnt_q      <= cnt_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    res_lst_q  <= res_lst_d;
    if (state_q == S_DONE && out_free) begin
      status_q <= res_st_q;
      slot_q   <= (res_st_q == cllm_pkg::ST_OK) ? cllm_pkg::SlotBits'(res_slot_q) : '0;
      lout_q   <= (res_st_q == cllm_pkg::ST_OK) ? cllm_pkg::ListBits'(res_lst_q) : '0;
    end
  end

  assign in_ready_o        = state_q == S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign list_number_out_o = lout_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISP)
    else $error("accepted item did not start decode");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NIL)
    else $error("free head out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != cllm_pkg::ST_OK |-> slot_q == '0 && lout_q == '0)
    else $error("failed item reports a slot");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> cnt_q < LW'(SLOTS))
    else $error("walk past slot count");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_free |=> state_q == S_DONE)
    else $error("result dropped while output busy");

endmodule
